// ----- rtl/vpt_pkg.sv -----
// ----------------------------------------------------------------------------
// vpt_pkg
// Shared constants and types for the velocity PI / torque controller.
// ----------------------------------------------------------------------------
package vpt_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 16;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_CONTROL_MODE      = 3'd0;
  localparam cfg_index_t REG_SPEED_BOUND       = 3'd1;
  localparam cfg_index_t REG_VEL_CAP           = 3'd2;
  localparam cfg_index_t REG_VEL_KP            = 3'd3;
  localparam cfg_index_t REG_INTEG_GAIN_PERIOD = 3'd4;
  localparam cfg_index_t REG_INTEG_LIMIT       = 3'd5;

  typedef struct packed {
    logic vel_mode;
    logic speed_bound;
  } vpt_mode_t;

endpackage

// ----- rtl/vpt_in_if.sv -----
// ----------------------------------------------------------------------------
// vpt_in_if
// Input item channel: commands, velocity estimate and torque limit.
// ----------------------------------------------------------------------------
interface vpt_in_if
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] vel_command;
  logic signed [DATA_WIDTH-1:0] torque_command;
  logic signed [DATA_WIDTH-1:0] vel_meas;
  logic                         estimate_valid;
  logic [DATA_WIDTH-2:0]        torque_cap;

  modport source (
    output valid, vel_command, torque_command, vel_meas, estimate_valid, torque_cap,
    input  ready
  );
  modport sink (
    input  valid, vel_command, torque_command, vel_meas, estimate_valid, torque_cap,
    output ready
  );
endinterface

// ----- rtl/vpt_out_if.sv -----
// ----------------------------------------------------------------------------
// vpt_out_if
// Result channel: torque drive value and step status.
// ----------------------------------------------------------------------------
interface vpt_out_if
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] torque_out;
  logic                         step_ok;
  logic                         estimate_error;

  modport source (
    output valid, torque_out, step_ok, estimate_error,
    input  ready
  );
  modport sink (
    input  valid, torque_out, step_ok, estimate_error,
    output ready
  );
endinterface

// ----- rtl/vpt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// vpt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vpt_cfg_if
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [DATA_WIDTH-2:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/vpt_datapath.sv -----
// ----------------------------------------------------------------------------
// vpt_datapath
// One control update: command clamping, PI law or speed bound, torque
// limiting and the next integrator value, all saturating fixed point.
// ----------------------------------------------------------------------------
module vpt_datapath
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  vpt_mode_t                    mode,
  input  logic [DATA_WIDTH-2:0]        vel_cap,
  input  logic [DATA_WIDTH-2:0]        vel_kp,
  input  logic [DATA_WIDTH-2:0]        integ_gain_times_period,
  input  logic [DATA_WIDTH-2:0]        integ_limit,
  input  logic signed [DATA_WIDTH-1:0] vel_command,
  input  logic signed [DATA_WIDTH-1:0] torque_command,
  input  logic signed [DATA_WIDTH-1:0] vel_meas,
  input  logic                         estimate_valid,
  input  logic [DATA_WIDTH-2:0]        torque_cap,
  input  logic signed [DATA_WIDTH-1:0] integ,
  output logic signed [DATA_WIDTH-1:0] torque,
  output logic signed [DATA_WIDTH-1:0] integ_next,
  output logic                         step_ok
);

  localparam int DW = DATA_WIDTH;
  localparam logic signed [DW-1:0] QMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] QMin = {1'b1, {(DW-1){1'b0}}};
  localparam logic [2*DW-1:0] Cap = (2*DW)'(1) << (DW-1);
  localparam logic signed [DW-1:0] Decay =
    DW'(((64'd99 << FRAC_BITS) + 64'd50) / 64'd100);

  function automatic logic signed [DW-1:0] sat_sum(input logic [DW:0] s);
    logic signed [DW-1:0] r;
    if (s[DW] != s[DW-1]) begin
      r = s[DW] ? QMin : QMax;
    end else begin
      r = signed'(s[DW-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    return sat_sum({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    return sat_sum({a[DW-1], a} - {b[DW-1], b});
  endfunction

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] x,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // sign-magnitude product, truncated toward zero, saturated
  function automatic logic signed [DW-1:0] mul_q(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic            neg;
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] q;
    logic [DW-1:0]   qc;
    logic signed [DW-1:0] r;
    neg  = a[DW-1] ^ b[DW-1];
    ma   = a[DW-1] ? -a : a;
    mb   = b[DW-1] ? -b : b;
    prod = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
    q    = prod >> FRAC_BITS;
    qc   = (q > Cap) ? Cap[DW-1:0] : q[DW-1:0];
    if (neg) begin
      r = signed'(-qc);
    end else if ({{DW{1'b0}}, qc} == Cap) begin
      r = QMax;
    end else begin
      r = signed'(qc);
    end
    return r;
  endfunction

  logic signed [DW-1:0] vlim_s;
  logic signed [DW-1:0] tlim_s;
  logic signed [DW-1:0] ilim_s;
  logic signed [DW-1:0] vgain_s;
  logic signed [DW-1:0] kip_s;
  logic signed [DW-1:0] vel_sp;
  logic signed [DW-1:0] torque_cmd_cl;
  logic signed [DW-1:0] vel_err;
  logic signed [DW-1:0] hi_err;
  logic signed [DW-1:0] lo_err;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [DW-1:0] decayed;
  logic signed [DW-1:0] torque_pre;
  logic signed [DW-1:0] integ_upd;
  logic                 limited;

  always_comb begin
    vlim_s  = signed'({1'b0, vel_cap});
    tlim_s  = signed'({1'b0, torque_cap});
    ilim_s  = signed'({1'b0, integ_limit});
    vgain_s = signed'({1'b0, vel_kp});
    kip_s   = signed'({1'b0, integ_gain_times_period});

    vel_sp        = clamp(vel_command, -vlim_s, vlim_s);
    torque_cmd_cl = clamp(torque_command, -tlim_s, tlim_s);
    vel_err       = sat_sub(vel_sp, vel_meas);
    hi_err        = sat_sub(vlim_s, vel_meas);
    lo_err        = sat_sub(-vlim_s, vel_meas);

    // velocity mode: proportional term and integrator increment
    // torque mode with speed bound: upper and lower torque bounds
    mul_a   = mul_q(vgain_s, mode.vel_mode ? vel_err : hi_err);
    mul_b   = mul_q(mode.vel_mode ? kip_s : vgain_s, mode.vel_mode ? vel_err : lo_err);
    decayed = mul_q(integ, Decay);

    if (mode.vel_mode) begin
      torque_pre = sat_add(mul_a, integ);
    end else if (mode.speed_bound) begin
      torque_pre = clamp(torque_cmd_cl, mul_b, mul_a);
    end else begin
      torque_pre = torque_cmd_cl;
    end

    limited = (torque_pre > tlim_s) || (torque_pre < -tlim_s);
    torque  = clamp(torque_pre, -tlim_s, tlim_s);

    integ_upd = limited ? decayed : sat_add(integ, mul_b);
    if (mode.vel_mode) begin
      integ_next = clamp(integ_upd, -ilim_s, ilim_s);
    end else begin
      integ_next = '0;
    end

    step_ok = !((mode.vel_mode || mode.speed_bound) && !estimate_valid);
  end

endmodule

// ----- rtl/velocity_pi_torque_controller.sv -----
// ----------------------------------------------------------------------------
// velocity_pi_torque_controller
// Velocity PI controller with anti-windup and torque-mode speed bound.
// Result is registered: valid in the cycle after the input transfer.
// Throughput: one item per cycle while the output is not stalled, set by the integrator update loop.
// Input is taken whenever the result register is empty or being drained.
// Reset clears registers, integrator, last torque and the sticky error flag.
// ----------------------------------------------------------------------------
module velocity_pi_torque_controller
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input logic    clk,
  input logic    rst,
  vpt_in_if.sink   in_ch,
  vpt_out_if.source out_ch,
  vpt_cfg_if.sink  cfg_ch
);

  vpt_mode_t                    mode;
  logic [DATA_WIDTH-2:0]        vel_cap;
  logic [DATA_WIDTH-2:0]        vel_kp;
  logic [DATA_WIDTH-2:0]        integ_gain_times_period;
  logic [DATA_WIDTH-2:0]        integ_limit;

  logic signed [DATA_WIDTH-1:0] integrator_torque;
  logic signed [DATA_WIDTH-1:0] last_torque;
  logic                         error_sticky;
  logic                         step_ok;
  logic                         out_valid;

  logic signed [DATA_WIDTH-1:0] torque_calc;
  logic signed [DATA_WIDTH-1:0] integrator_torque_next;
  logic                         step_ok_calc;
  logic                         in_xfer;

  vpt_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .mode                    (mode),
    .vel_cap                 (vel_cap),
    .vel_kp                  (vel_kp),
    .integ_gain_times_period (integ_gain_times_period),
    .integ_limit             (integ_limit),
    .vel_command             (in_ch.vel_command),
    .torque_command          (in_ch.torque_command),
    .vel_meas                (in_ch.vel_meas),
    .estimate_valid          (in_ch.estimate_valid),
    .torque_cap              (in_ch.torque_cap),
    .integ                   (integrator_torque),
    .torque                  (torque_calc),
    .integ_next              (integrator_torque_next),
    .step_ok                 (step_ok_calc)
  );

  assign in_ch.ready  = !rst && (!out_valid || out_ch.ready);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid;
  assign out_ch.torque_out     = last_torque;
  assign out_ch.step_ok        = step_ok;
  assign out_ch.estimate_error = error_sticky;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                    <= '0;
      vel_cap                 <= '0;
      vel_kp                  <= '0;
      integ_gain_times_period <= '0;
      integ_limit             <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_CONTROL_MODE:      mode.vel_mode           <= cfg_ch.data[0];
        REG_SPEED_BOUND:       mode.speed_bound        <= cfg_ch.data[0];
        REG_VEL_CAP:           vel_cap                 <= cfg_ch.data;
        REG_VEL_KP:            vel_kp                  <= cfg_ch.data;
        REG_INTEG_GAIN_PERIOD: integ_gain_times_period <= cfg_ch.data;
        REG_INTEG_LIMIT:       integ_limit             <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator_torque <= '0;
      last_torque       <= '0;
      error_sticky      <= 1'b0;
      step_ok           <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (in_xfer) begin
        out_valid <= 1'b1;
        step_ok   <= step_ok_calc;
        if (step_ok_calc) begin
          integrator_torque <= integrator_torque_next;
          last_torque       <= torque_calc;
        end else begin
          error_sticky <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/vpt_checker.sv -----
// ----------------------------------------------------------------------------
// vpt_checker
// Port-level checks for the controller, bound to the top level.
// ----------------------------------------------------------------------------
module vpt_checker
  import vpt_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] torque_out,
  input logic                         step_ok,
  input logic                         estimate_error
);

  // a failed step keeps the previous torque
  a_hold_on_fail: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> step_ok || $stable(torque_out))
    else $error("torque changed on failed step");

  // a failed step always reports the error flag
  a_fail_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_ok |-> estimate_error)
    else $error("failed step without error flag");

  // error flag is sticky until reset
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    estimate_error |=> estimate_error)
    else $error("error flag dropped");

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

endmodule

bind velocity_pi_torque_controller vpt_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_vpt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .torque_out     (out_ch.torque_out),
  .step_ok        (out_ch.step_ok),
  .estimate_error (out_ch.estimate_error)
);
